>>> rtl/wwst_pkg.sv
`default_nettype none

package wwst_pkg;

   // table geometry
   localparam int unsigned Depth = 256;
   localparam int unsigned IdxW  = $clog2(Depth);
   localparam int unsigned CntW  = $clog2(Depth + 1);

   // arithmetic widths
   localparam int unsigned WeightW = 21;                  // 100 * 100 * 200 max
   localparam int unsigned ProdW   = 38;                  // wind * weight, signed
   localparam int unsigned AccW    = ProdW + CntW;        // weighted wind sums
   localparam int unsigned TotW    = WeightW + CntW;      // weight sum
   localparam int unsigned DivNW   = AccW;                // dividend width
   localparam int unsigned DivDW   = (TotW > 27) ? TotW : 27;
   localparam int unsigned DivCntW = $clog2(DivNW);
   localparam int unsigned ScoreW  = 35;
   localparam int unsigned MulAW   = 18;
   localparam int unsigned MulBW   = 22;
   localparam int unsigned MulPW   = MulAW + MulBW;

   localparam logic [2:0] QualOverride = 3'd6;

   typedef enum logic {
      OP_ADD   = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      CSR_ALT_WINDOW  = 1'b0,
      CSR_TIME_WINDOW = 1'b1
   } csr_idx_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_A_RD,
      ST_A_EVAL,
      ST_A_WR,
      ST_Q_RD,
      ST_Q_TEST,
      ST_Q_AD,
      ST_Q_ADSQ,
      ST_Q_AS,
      ST_Q_TD,
      ST_Q_TDSQ,
      ST_Q_TS,
      ST_Q_AFMUL,
      ST_Q_AFGO,
      ST_Q_AF,
      ST_Q_TFDMUL,
      ST_Q_TFD,
      ST_Q_TFNMUL,
      ST_Q_TFGO,
      ST_Q_TF,
      ST_Q_W1,
      ST_Q_W2,
      ST_Q_OVR,
      ST_Q_SX,
      ST_Q_SY,
      ST_Q_ACC,
      ST_Q_NEXT,
      ST_Q_FIN,
      ST_Q_DX,
      ST_Q_DY
   } state_type;

   typedef struct packed {
      logic signed [15:0] wind_x;
      logic signed [15:0] wind_y;
      logic signed [15:0] alt;
      logic [31:0]        tim;
      logic [2:0]         qual;
   } entry_type;

   typedef struct packed {
      logic             start;
      logic [DivNW-1:0] num;
      logic [DivDW-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DivNW-1:0] quot;
   } div_rsp_type;

   // min(q,5)*20
   function automatic logic [6:0] qual_factor(input logic [2:0] q);
      logic [6:0] f;
      case (q)
         3'd0:    f = 7'd0;
         3'd1:    f = 7'd20;
         3'd2:    f = 7'd40;
         3'd3:    f = 7'd60;
         3'd4:    f = 7'd80;
         default: f = 7'd100;
      endcase
      return f;
   endfunction

   // 600*(6-q)
   function automatic logic signed [12:0] score_bias(input logic [2:0] q);
      logic signed [12:0] b;
      case (q)
         3'd0:    b = 13'sd3600;
         3'd1:    b = 13'sd3000;
         3'd2:    b = 13'sd2400;
         3'd3:    b = 13'sd1800;
         3'd4:    b = 13'sd1200;
         3'd5:    b = 13'sd600;
         3'd6:    b = 13'sd0;
         default: b = -13'sd600;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

>>> rtl/wwst_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module wwst_div (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire wwst_pkg::div_req_type req,
   output wwst_pkg::div_rsp_type     rsp
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [wwst_pkg::DivCntW-1:0]  cnt_ff, cnt_in;
   logic [wwst_pkg::DivNW-1:0]    quo_ff, quo_in;
   logic [wwst_pkg::DivDW-1:0]    rem_ff, rem_in;
   logic [wwst_pkg::DivDW-1:0]    den_ff, den_in;
   logic [wwst_pkg::DivDW:0]      shifted;
   logic [wwst_pkg::DivDW:0]      trial;

   assign shifted = {rem_ff, quo_ff[wwst_pkg::DivNW-1]};
   assign trial   = shifted - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = wwst_pkg::DivCntW'(wwst_pkg::DivNW - 1);
         quo_in  = req.num;
         rem_in  = '0;
         den_in  = req.den;
      end else if (busy_ff) begin
         if (!trial[wwst_pkg::DivDW]) begin
            rem_in = trial[wwst_pkg::DivDW-1:0];
         end else begin
            rem_in = shifted[wwst_pkg::DivDW-1:0];
         end
         quo_in = {quo_ff[wwst_pkg::DivNW-2:0], ~trial[wwst_pkg::DivDW]};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

endmodule

`default_nettype wire

>>> rtl/weighted_wind_store_unit.sv
`default_nettype none

// Weighted wind store: a table of up to 256 wind measurements.
// Input channel: pulse start with req_* valid while busy is low; the transfer
// happens on that edge and busy rises on the next cycle.
//   req_operation = add: stores the measurement. When the table is full the
//   entry with the highest score 600*(6-quality)+age is overwritten. No result.
//   req_operation = query: walks the stored entries, keeps those inside the
//   altitude and time windows and returns the weighted mean wind.
// Result channel: rsp_valid is high for exactly one cycle with rsp_found,
// rsp_mean_x, rsp_mean_y. The receiver cannot stall; rsp_found and the means
// keep their values on the ports until a later query rewrites them.
// Sequencing: one item at a time. An add into a table with room goes straight
// to the write; into a full table the victim scan first reads and scores every
// stored entry. A query reads the entries in turn: one inside both windows runs
// four divisions on the bit-serial divider (DIV = 47 bits, the dividend width)
// and the weight products, an override entry that is skipped leaves out the
// accumulate, and one outside is only tested; the final mean takes two more
// divisions (none when the weight sum is zero). Divider and multiplier are shared.
// Configuration: APB registers alt_window (0x0) and time_window (0x4).
// Reset: empties the table and loads the window defaults (1000 m, 3600 s).
module weighted_wind_store_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   // command channel
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_operation,
   input  wire logic [31:0]        req_time_now,
   input  wire logic signed [15:0] req_altitude,
   input  wire logic signed [15:0] req_wind_x,
   input  wire logic signed [15:0] req_wind_y,
   input  wire logic [2:0]         req_quality,
   // result channel
   output logic                    rsp_valid,
   output logic                    rsp_found,
   output logic signed [15:0]      rsp_mean_x,
   output logic signed [15:0]      rsp_mean_y,
   // register port
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   localparam int unsigned IdxW  = wwst_pkg::IdxW;
   localparam int unsigned CntW  = wwst_pkg::CntW;
   localparam int unsigned AccW  = wwst_pkg::AccW;
   localparam int unsigned TotW  = wwst_pkg::TotW;
   localparam int unsigned WgtW  = wwst_pkg::WeightW;
   localparam int unsigned DivNW = wwst_pkg::DivNW;
   localparam int unsigned DivDW = wwst_pkg::DivDW;
   localparam int unsigned ScW   = wwst_pkg::ScoreW;
   localparam int unsigned MulAW = wwst_pkg::MulAW;
   localparam int unsigned MulBW = wwst_pkg::MulBW;
   localparam int unsigned MulPW = wwst_pkg::MulPW;

   // ---------------- registers ----------------
   wwst_pkg::state_type state_ff, state_in;
   logic [15:0]         alt_win_ff, alt_win_in;
   logic [15:0]         time_win_ff, time_win_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                rsp_found_ff, rsp_found_in;
   logic signed [15:0]  rsp_mean_x_ff, rsp_mean_x_in;
   logic signed [15:0]  rsp_mean_y_ff, rsp_mean_y_in;
   logic [31:0]         now_ff, now_in;
   logic signed [15:0]  alt_ff, alt_in;
   logic signed [15:0]  wx_ff, wx_in;
   logic signed [15:0]  wy_ff, wy_in;
   logic [2:0]          qual_ff, qual_in;
   logic [IdxW-1:0]     idx_ff, idx_in;
   logic [IdxW-1:0]     pick_ff, pick_in;
   logic signed [ScW-1:0] best_ff, best_in;
   logic [15:0]         adt_ff, adt_in;
   logic [16:0]         ad_ff, ad_in;
   logic [16:0]         as_ff, as_in;
   logic [16:0]         td_ff, td_in;
   logic [16:0]         ts_ff, ts_in;
   logic [6:0]          af_ff, af_in;
   logic [7:0]          tf_ff, tf_in;
   logic [25:0]         tfd_ff, tfd_in;
   logic [WgtW-1:0]     w_ff, w_in;
   logic signed [MulPW-1:0] mul_ff;
   logic signed [AccW-1:0]  sx_ff, sx_in;
   logic signed [AccW-1:0]  sy_ff, sy_in;
   logic [TotW-1:0]     tot_ff, tot_in;
   logic [16:0]         ov_ff, ov_in;
   logic                ovd_ff, ovd_in;
   logic                neg_ff, neg_in;

   wwst_pkg::entry_type rd_ff;
   wwst_pkg::entry_type entry_mem [wwst_pkg::Depth];

   // ---------------- combinational helpers ----------------
   logic                    accept;
   logic                    mem_we;
   logic signed [MulAW-1:0] mul_a;
   logic signed [MulBW-1:0] mul_b;
   wwst_pkg::div_req_type   div_req;
   wwst_pkg::div_rsp_type   div_rsp;
   logic signed [ScW-1:0]   score;
   logic signed [16:0]      da;
   logic [15:0]             ada;
   logic [32:0]             dt;
   logic [32:0]             adt;
   logic                    keep;
   logic [33:0]             sq_rnd;
   logic [16:0]             sq_val;
   logic [17:0]             afd;
   logic [AccW-1:0]         sx_abs;
   logic [AccW-1:0]         sy_abs;
   logic                    skip;
   logic                    last;
   logic [15:0]             quot_lo;
   logic [6:0]              qf;
   logic                    cfg_wr;

   assign accept = start && !busy;
   assign busy   = (state_ff != wwst_pkg::ST_IDLE);

   always_comb begin
      score  = ScW'(wwst_pkg::score_bias(rd_ff.qual))
             + signed'(ScW'({1'b0, now_ff})) - signed'(ScW'({1'b0, rd_ff.tim}));
      da     = {alt_ff[15], alt_ff} - {rd_ff.alt[15], rd_ff.alt};
      ada    = da[16] ? 16'(-da) : da[15:0];
      dt     = {1'b0, now_ff} - {1'b0, rd_ff.tim};
      adt    = dt[32] ? (-dt) : dt;
      keep   = (ada < alt_win_ff) && (adt < {17'd0, time_win_ff});
      sq_rnd = mul_ff[33:0] + 34'd32768;
      sq_val = sq_rnd[32:16];
      afd    = 18'd65536 + 18'(as_ff);
      sx_abs = sx_ff[AccW-1] ? AccW'(-sx_ff) : AccW'(sx_ff);
      sy_abs = sy_ff[AccW-1] ? AccW'(-sy_ff) : AccW'(sy_ff);
      skip   = (rd_ff.qual == wwst_pkg::QualOverride) && !(td_ff < ov_ff);
      last   = ((CntW'(idx_ff) + 1'b1) == cnt_ff);
      quot_lo = div_rsp.quot[15:0];
      qf     = wwst_pkg::qual_factor(rd_ff.qual);
   end

   // ---------------- sequencer: next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wwst_pkg::ST_IDLE: begin
            if (accept) begin
               if (wwst_pkg::op_type'(req_operation) == wwst_pkg::OP_ADD) begin
                  state_in = (cnt_ff == CntW'(wwst_pkg::Depth)) ?
                             wwst_pkg::ST_A_RD : wwst_pkg::ST_A_WR;
               end else begin
                  state_in = (cnt_ff == '0) ? wwst_pkg::ST_Q_FIN : wwst_pkg::ST_Q_RD;
               end
            end
         end
         wwst_pkg::ST_A_RD:     state_in = wwst_pkg::ST_A_EVAL;
         wwst_pkg::ST_A_EVAL:   state_in = (idx_ff == '0) ? wwst_pkg::ST_A_WR
                                                          : wwst_pkg::ST_A_RD;
         wwst_pkg::ST_A_WR:     state_in = wwst_pkg::ST_IDLE;
         wwst_pkg::ST_Q_RD:     state_in = wwst_pkg::ST_Q_TEST;
         wwst_pkg::ST_Q_TEST:   state_in = keep ? wwst_pkg::ST_Q_AD : wwst_pkg::ST_Q_NEXT;
         wwst_pkg::ST_Q_AD:     if (div_rsp.done) state_in = wwst_pkg::ST_Q_ADSQ;
         wwst_pkg::ST_Q_ADSQ:   state_in = wwst_pkg::ST_Q_AS;
         wwst_pkg::ST_Q_AS:     state_in = wwst_pkg::ST_Q_TD;
         wwst_pkg::ST_Q_TD:     if (div_rsp.done) state_in = wwst_pkg::ST_Q_TDSQ;
         wwst_pkg::ST_Q_TDSQ:   state_in = wwst_pkg::ST_Q_TS;
         wwst_pkg::ST_Q_TS:     state_in = wwst_pkg::ST_Q_AFMUL;
         wwst_pkg::ST_Q_AFMUL:  state_in = wwst_pkg::ST_Q_AFGO;
         wwst_pkg::ST_Q_AFGO:   state_in = wwst_pkg::ST_Q_AF;
         wwst_pkg::ST_Q_AF:     if (div_rsp.done) state_in = wwst_pkg::ST_Q_TFDMUL;
         wwst_pkg::ST_Q_TFDMUL: state_in = wwst_pkg::ST_Q_TFD;
         wwst_pkg::ST_Q_TFD:    state_in = wwst_pkg::ST_Q_TFNMUL;
         wwst_pkg::ST_Q_TFNMUL: state_in = wwst_pkg::ST_Q_TFGO;
         wwst_pkg::ST_Q_TFGO:   state_in = wwst_pkg::ST_Q_TF;
         wwst_pkg::ST_Q_TF:     if (div_rsp.done) state_in = wwst_pkg::ST_Q_W1;
         wwst_pkg::ST_Q_W1:     state_in = wwst_pkg::ST_Q_W2;
         wwst_pkg::ST_Q_W2:     state_in = wwst_pkg::ST_Q_OVR;
         wwst_pkg::ST_Q_OVR:    state_in = skip ? wwst_pkg::ST_Q_NEXT : wwst_pkg::ST_Q_SX;
         wwst_pkg::ST_Q_SX:     state_in = wwst_pkg::ST_Q_SY;
         wwst_pkg::ST_Q_SY:     state_in = wwst_pkg::ST_Q_ACC;
         wwst_pkg::ST_Q_ACC:    state_in = wwst_pkg::ST_Q_NEXT;
         wwst_pkg::ST_Q_NEXT:   state_in = last ? wwst_pkg::ST_Q_FIN : wwst_pkg::ST_Q_RD;
         wwst_pkg::ST_Q_FIN:    state_in = (tot_ff == '0) ? wwst_pkg::ST_IDLE
                                                          : wwst_pkg::ST_Q_DX;
         wwst_pkg::ST_Q_DX:     if (div_rsp.done) state_in = wwst_pkg::ST_Q_DY;
         wwst_pkg::ST_Q_DY:     if (div_rsp.done) state_in = wwst_pkg::ST_IDLE;
         default:               state_in = wwst_pkg::ST_IDLE;
      endcase
   end

   // ---------------- sequencer: datapath controls ----------------
   always_comb begin
      cnt_in        = cnt_ff;
      rsp_valid_in  = 1'b0;
      rsp_found_in  = rsp_found_ff;
      rsp_mean_x_in = rsp_mean_x_ff;
      rsp_mean_y_in = rsp_mean_y_ff;
      now_in  = now_ff;
      alt_in  = alt_ff;
      wx_in   = wx_ff;
      wy_in   = wy_ff;
      qual_in = qual_ff;
      idx_in  = idx_ff;
      pick_in = pick_ff;
      best_in = best_ff;
      adt_in  = adt_ff;
      ad_in   = ad_ff;
      as_in   = as_ff;
      td_in   = td_ff;
      ts_in   = ts_ff;
      af_in   = af_ff;
      tf_in   = tf_ff;
      tfd_in  = tfd_ff;
      w_in    = w_ff;
      sx_in   = sx_ff;
      sy_in   = sy_ff;
      tot_in  = tot_ff;
      ov_in   = ov_ff;
      ovd_in  = ovd_ff;
      neg_in  = neg_ff;
      mul_a   = '0;
      mul_b   = '0;
      div_req = '0;
      mem_we  = 1'b0;

      unique case (state_ff)
         wwst_pkg::ST_IDLE: begin
            if (accept) begin
               now_in  = req_time_now;
               alt_in  = req_altitude;
               wx_in   = req_wind_x;
               wy_in   = req_wind_y;
               qual_in = req_quality;
               if (wwst_pkg::op_type'(req_operation) == wwst_pkg::OP_ADD) begin
                  if (cnt_ff == CntW'(wwst_pkg::Depth)) begin
                     // full: scan down from the last entry
                     idx_in  = IdxW'(wwst_pkg::Depth - 1);
                     pick_in = IdxW'(wwst_pkg::Depth - 1);
                     best_in = '0;
                  end else begin
                     pick_in = cnt_ff[IdxW-1:0];
                     cnt_in  = cnt_ff + 1'b1;
                  end
               end else begin
                  idx_in = '0;
                  sx_in  = '0;
                  sy_in  = '0;
                  tot_in = '0;
                  ov_in  = '1;
                  ovd_in = 1'b0;
               end
            end
         end
         wwst_pkg::ST_A_EVAL: begin
            if (score > best_ff) begin
               best_in = score;
               pick_in = idx_ff;
            end
            if (idx_ff != '0) begin
               idx_in = idx_ff - 1'b1;
            end
         end
         wwst_pkg::ST_A_WR: begin
            mem_we = 1'b1;
         end
         wwst_pkg::ST_Q_TEST: begin
            if (keep) begin
               adt_in        = adt[15:0];
               div_req.start = 1'b1;
               div_req.num   = DivNW'({ada, 16'd0}) + DivNW'(alt_win_ff[15:1]);
               div_req.den   = DivDW'(alt_win_ff);
            end
         end
         wwst_pkg::ST_Q_AD: begin
            if (div_rsp.done) ad_in = div_rsp.quot[16:0];
         end
         wwst_pkg::ST_Q_ADSQ: begin
            mul_a = MulAW'(ad_ff);
            mul_b = MulBW'(ad_ff);
         end
         wwst_pkg::ST_Q_AS: begin
            as_in         = sq_val;
            div_req.start = 1'b1;
            div_req.num   = DivNW'({adt_ff, 16'd0}) + DivNW'(time_win_ff[15:1]);
            div_req.den   = DivDW'(time_win_ff);
         end
         wwst_pkg::ST_Q_TD: begin
            if (div_rsp.done) td_in = div_rsp.quot[16:0];
         end
         wwst_pkg::ST_Q_TDSQ: begin
            mul_a = MulAW'(td_ff);
            mul_b = MulBW'(td_ff);
         end
         wwst_pkg::ST_Q_TS: begin
            ts_in = sq_val;
         end
         wwst_pkg::ST_Q_AFMUL: begin
            mul_a = MulAW'(100);
            mul_b = MulBW'(17'd65536 - as_ff);
         end
         wwst_pkg::ST_Q_AFGO: begin
            // round(num/den) as (2*num + den) / (2*den)
            div_req.start = 1'b1;
            div_req.num   = DivNW'({mul_ff[23:0], 1'b0}) + DivNW'(afd);
            div_req.den   = DivDW'({afd, 1'b0});
         end
         wwst_pkg::ST_Q_AF: begin
            if (div_rsp.done) af_in = div_rsp.quot[6:0];
         end
         wwst_pkg::ST_Q_TFDMUL: begin
            mul_a = MulAW'(400);
            mul_b = MulBW'(ts_ff);
         end
         wwst_pkg::ST_Q_TFD: begin
            tfd_in = mul_ff[25:0] + 26'd65536;
         end
         wwst_pkg::ST_Q_TFNMUL: begin
            mul_a = MulAW'(200);
            mul_b = MulBW'(17'd65536 - td_ff);
         end
         wwst_pkg::ST_Q_TFGO: begin
            div_req.start = 1'b1;
            div_req.num   = DivNW'({mul_ff[24:0], 1'b0}) + DivNW'(tfd_ff);
            div_req.den   = DivDW'({tfd_ff, 1'b0});
         end
         wwst_pkg::ST_Q_TF: begin
            if (div_rsp.done) tf_in = div_rsp.quot[7:0];
         end
         wwst_pkg::ST_Q_W1: begin
            mul_a = MulAW'(af_ff);
            mul_b = MulBW'(qf);
         end
         wwst_pkg::ST_Q_W2: begin
            mul_a = MulAW'(tf_ff);
            mul_b = MulBW'(mul_ff[13:0]);
         end
         wwst_pkg::ST_Q_OVR: begin
            w_in = mul_ff[WgtW-1:0];
            if (rd_ff.qual == wwst_pkg::QualOverride) begin
               // override entry restarts the sums when it is the newest so far
               if (td_ff < ov_ff) begin
                  ov_in  = td_ff;
                  ovd_in = 1'b1;
                  sx_in  = '0;
                  sy_in  = '0;
                  tot_in = '0;
               end
            end else if (td_ff < ov_ff) begin
               ov_in = td_ff;
               if (ovd_ff) begin
                  ovd_in = 1'b0;
                  sx_in  = '0;
                  sy_in  = '0;
                  tot_in = '0;
               end
            end
         end
         wwst_pkg::ST_Q_SX: begin
            mul_a = MulAW'(rd_ff.wind_x);
            mul_b = MulBW'(w_ff);
         end
         wwst_pkg::ST_Q_SY: begin
            sx_in = sx_ff + AccW'(mul_ff);
            mul_a = MulAW'(rd_ff.wind_y);
            mul_b = MulBW'(w_ff);
         end
         wwst_pkg::ST_Q_ACC: begin
            sy_in  = sy_ff + AccW'(mul_ff);
            tot_in = tot_ff + TotW'(w_ff);
         end
         wwst_pkg::ST_Q_NEXT: begin
            if (!last) idx_in = idx_ff + 1'b1;
         end
         wwst_pkg::ST_Q_FIN: begin
            if (tot_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = 1'b0;
               rsp_mean_x_in = '0;
               rsp_mean_y_in = '0;
            end else begin
               neg_in        = sx_ff[AccW-1];
               div_req.start = 1'b1;
               div_req.num   = DivNW'(sx_abs);
               div_req.den   = DivDW'(tot_ff);
            end
         end
         wwst_pkg::ST_Q_DX: begin
            if (div_rsp.done) begin
               rsp_mean_x_in = neg_ff ? -quot_lo : quot_lo;
               neg_in        = sy_ff[AccW-1];
               div_req.start = 1'b1;
               div_req.num   = DivNW'(sy_abs);
               div_req.den   = DivDW'(tot_ff);
            end
         end
         wwst_pkg::ST_Q_DY: begin
            if (div_rsp.done) begin
               rsp_mean_y_in = neg_ff ? -quot_lo : quot_lo;
               rsp_found_in  = 1'b1;
               rsp_valid_in  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // shared divider
   wwst_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // ---------------- register port ----------------
   assign cfg_wr = psel && penable && pwrite && pready;
   assign pready = 1'b1;

   always_comb begin
      alt_win_in  = alt_win_ff;
      time_win_in = time_win_ff;
      if (cfg_wr) begin
         unique case (wwst_pkg::csr_idx_type'(paddr[2:2]))
            wwst_pkg::CSR_ALT_WINDOW:  alt_win_in  = pwdata[15:0];
            wwst_pkg::CSR_TIME_WINDOW: time_win_in = pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (wwst_pkg::csr_idx_type'(paddr[2:2]))
         wwst_pkg::CSR_ALT_WINDOW:  prdata = 32'(alt_win_ff);
         wwst_pkg::CSR_TIME_WINDOW: prdata = 32'(time_win_ff);
         default:                   prdata = '0;
      endcase
   end

   // ---------------- state ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wwst_pkg::ST_IDLE;
         alt_win_ff   <= 16'd1000;
         time_win_ff  <= 16'd3600;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         alt_win_ff   <= alt_win_in;
         time_win_ff  <= time_win_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff  <= rsp_found_in;
      rsp_mean_x_ff <= rsp_mean_x_in;
      rsp_mean_y_ff <= rsp_mean_y_in;
      now_ff  <= now_in;
      alt_ff  <= alt_in;
      wx_ff   <= wx_in;
      wy_ff   <= wy_in;
      qual_ff <= qual_in;
      idx_ff  <= idx_in;
      pick_ff <= pick_in;
      best_ff <= best_in;
      adt_ff  <= adt_in;
      ad_ff   <= ad_in;
      as_ff   <= as_in;
      td_ff   <= td_in;
      ts_ff   <= ts_in;
      af_ff   <= af_in;
      tf_ff   <= tf_in;
      tfd_ff  <= tfd_in;
      w_ff    <= w_in;
      mul_ff  <= mul_a * mul_b;
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      tot_ff  <= tot_in;
      ov_ff   <= ov_in;
      ovd_ff  <= ovd_in;
      neg_ff  <= neg_in;
   end

   // entry table, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[pick_ff] <= '{wind_x: wx_ff, wind_y: wy_ff, alt: alt_ff,
                                 tim: now_ff, qual: qual_ff};
      end
      rd_ff <= entry_mem[idx_ff];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_mean_x = rsp_mean_x_ff;
   assign rsp_mean_y = rsp_mean_y_ff;

`ifndef SYNTHESIS
   // a result transfer only comes out as the sequencer returns to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result transfer while busy");

   // the fill count never passes the table depth
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(wwst_pkg::Depth))
      else $error("entry count beyond depth");

   // the divider is never restarted mid-division
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   // an empty result carries zero means
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_mean_x == '0 && rsp_mean_y == '0))
      else $error("nonzero mean without a match");
`endif

endmodule

`default_nettype wire
